// ===== hdl/kdlp_pkg.sv =====
// Shared types and constants for the key debounce and long-press detector.
// No dependencies; the interface, core and top-level files refer to it by scoped names.
`default_nettype none

package kdlp_pkg;

  localparam int unsigned DebounceW = 8;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [DebounceW-1:0] DebounceCountRst = 8'd5;
  localparam logic [HoldW-1:0]     LongPressRst     = 16'd300;
  localparam logic                 LevelPressed     = 1'b1;

  typedef enum logic [0:0] {
    REG_DEBOUNCE_COUNT   = 1'b0,
    REG_LONG_PRESS_TICKS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_count;
    logic [HoldW-1:0]     long_press_ticks;
  } kdlp_cfg_t;

  typedef struct packed {
    logic emit;
    logic key_event;
  } kdlp_result_t;

endpackage

`default_nettype wire

// ===== hdl/kdlp_intf.sv =====
// Valid/ready channel interfaces for key samples, key events and register writes.
// Depends on kdlp_pkg for field widths and the register index type.
`default_nettype none

interface kdlp_key_if;
  logic valid;
  logic ready;
  logic key_pressed;

  modport source (output valid, output key_pressed, input ready);
  modport sink (input valid, input key_pressed, output ready);
endinterface

interface kdlp_event_if;
  logic valid;
  logic ready;
  logic key_event;

  modport source (output valid, output key_event, input ready);
  modport sink (input valid, input key_event, output ready);
endinterface

interface kdlp_cfg_if;
  logic                            valid;
  logic                            ready;
  kdlp_pkg::cfg_reg_e              index;
  logic [kdlp_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/kdlp_core.sv =====
// Scan-phase machine: debounce, hold timing and event reporting for one tick.
// Depends on kdlp_pkg for the configuration and result structs.
`default_nettype none

module kdlp_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   level_i,
  input  kdlp_pkg::kdlp_cfg_t    cfg_i,
  output kdlp_pkg::kdlp_result_t result_o
);

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_SCAN     = 2'd1,
    PH_DEBOUNCE = 2'd2,
    PH_WAIT     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  phase_e                          phase_q, phase_d;
  logic [kdlp_pkg::DebounceW-1:0]  cnt_q, cnt_d;
  logic                            latched_q, latched_d;
  event_e                          pend_q, pend_d;
  event_e                          cur_q, cur_d;
  event_e                          last_q, last_d;
  logic [kdlp_pkg::HoldW-1:0]      hold_q, hold_d;
  logic                            emit;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    latched_d = latched_q;
    pend_d    = pend_q;
    cur_d     = cur_q;
    last_d    = last_q;
    hold_d    = hold_q;
    unique case (phase_q)
      PH_IDLE: begin
        cnt_d     = '0;
        latched_d = 1'b0;
        cur_d     = EV_NONE;
        last_d    = EV_NONE;
        hold_d    = '0;
        phase_d   = PH_SCAN;
      end
      PH_SCAN: begin
        latched_d = level_i;
        phase_d   = (level_i == kdlp_pkg::LevelPressed) ? PH_DEBOUNCE : PH_IDLE;
      end
      PH_DEBOUNCE: begin
        if (level_i == latched_q) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_d == cfg_i.debounce_count) begin
            phase_d = PH_WAIT;
            cnt_d   = '0;
            pend_d  = EV_SHORT;
          end
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (level_i != latched_q) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_d == cfg_i.debounce_count && level_i != kdlp_pkg::LevelPressed) begin
            phase_d = PH_IDLE;
            cur_d   = pend_q;
          end
        end else begin
          hold_d = hold_q + 1'b1;
          if (hold_d >= cfg_i.long_press_ticks) begin
            pend_d = EV_LONG;
            cur_d  = EV_LONG;
            hold_d = '0;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
    emit = (cur_d != EV_NONE) && (cur_d != last_d);
    if (emit) begin
      last_d = cur_d;
    end
  end

  assign result_o.emit      = step_i && emit;
  assign result_o.key_event = (cur_d == EV_LONG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      cnt_q     <= '0;
      latched_q <= 1'b0;
      pend_q    <= EV_NONE;
      cur_q     <= EV_NONE;
      last_q    <= EV_NONE;
      hold_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      latched_q <= latched_d;
      pend_q    <= pend_d;
      cur_q     <= cur_d;
      last_q    <= last_d;
      hold_q    <= hold_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/key_debounce_long_press_top.sv =====
// Top level of the key debounce and long-press detector.
// Depends on kdlp_pkg, the channel interfaces in kdlp_intf.sv and kdlp_core.
`default_nettype none

// Each key beat is one scan tick. The block takes one beat per clock cycle
// while the event output is not stalled: a beat waits in the input register,
// the phase machine updates its state from it, and any event it raises lands in
// the output register; the event beat is valid once it is in that register.
// The input stage stalls only while an event beat waits in the output register
// and the next beat also needs to move. Ticks that raise no event give no beat.
// Register writes take effect the cycle after the write beat and are always
// accepted; index 0 is the debounce count, index 1 the long-press tick limit.
module key_debounce_long_press_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  kdlp_key_if.sink        key_i,
  kdlp_event_if.source    event_o,
  kdlp_cfg_if.sink        cfg_i
);

  kdlp_pkg::kdlp_cfg_t    cfg_q;
  kdlp_pkg::kdlp_result_t result;
  logic                   in_valid_q;
  logic                   in_level_q;
  logic                   out_valid_q;
  logic                   out_event_q;
  logic                   advance;
  logic                   accept;

  assign advance     = in_valid_q && (!out_valid_q || event_o.ready);
  assign key_i.ready = !in_valid_q || advance;
  assign accept      = key_i.valid && key_i.ready;
  assign cfg_i.ready = 1'b1;

  assign event_o.valid     = out_valid_q;
  assign event_o.key_event = out_event_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_count   <= kdlp_pkg::DebounceCountRst;
      cfg_q.long_press_ticks <= kdlp_pkg::LongPressRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        kdlp_pkg::REG_DEBOUNCE_COUNT:
          cfg_q.debounce_count <= cfg_i.data[kdlp_pkg::DebounceW-1:0];
        kdlp_pkg::REG_LONG_PRESS_TICKS:
          cfg_q.long_press_ticks <= cfg_i.data[kdlp_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_level_q <= key_i.key_pressed;
    end
  end

  kdlp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .level_i  (in_level_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.emit) begin
      out_valid_q <= 1'b1;
    end else if (event_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.emit) begin
      out_event_q <= result.key_event;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kdlp_checker.sv =====
// Port-level checks for key_debounce_long_press_top, attached by bind.
// Depends only on the top level's channel signals.
`default_nettype none

module kdlp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic key_ready_i,
  input logic event_valid_i,
  input logic event_ready_i,
  input logic event_key_i,
  input logic cfg_valid_i,
  input logic cfg_ready_i
);

  a_event_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_i && !event_ready_i |=> event_valid_i)
    else $error("event beat dropped while stalled");

  a_event_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_valid_i && !event_ready_i |=> $stable(event_key_i))
    else $error("event payload changed while stalled");

  a_key_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !key_ready_i |-> event_valid_i && !event_ready_i)
    else $error("key channel stalled without a pending event beat");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("register write not accepted");

endmodule

bind key_debounce_long_press_top kdlp_checker u_kdlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .key_ready_i   (key_i.ready),
  .event_valid_i (event_o.valid),
  .event_ready_i (event_o.ready),
  .event_key_i   (event_o.key_event),
  .cfg_valid_i   (cfg_i.valid),
  .cfg_ready_i   (cfg_i.ready)
);

`default_nettype wire
